[hdl/spq_pkg.sv]
// spq_pkg: shared constants and types for the stack percentile quality block
// no dependencies; imported by every module under hdl

package spq_pkg;

  // default build values for the top-level parameters
  localparam int STACK_DEPTH_DEF  = 8;
  localparam int QUALITY_BITS_DEF = 16;

  // configuration register layout
  localparam int RATIO_W    = 17;
  localparam int ACTIVE_W   = 4;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [RATIO_W-1:0]  RATIO_RESET  = 17'h10000;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  // fraction bits of the ratio (unsigned Q1.16)
  localparam int RATIO_FRAC = 16;

  // register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RATIO  = 1'b0,
    REG_ACTIVE = 1'b1
  } cfg_reg_t;

endpackage

[hdl/stack_percentile_quality.sv]
// stack_percentile_quality: top level, percentile target and closeness scores
// depends on spq_pkg, spq_cell, spq_select, spq_score
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata: quality_0 .. quality_N-1
//  out_    | out | out_tvalid/tready  | out_tdata: target_quality, closeness_0 ..
//  cfg_    | in  | cfg_we             | cfg_addr, cfg_wdata
//
// one word per cycle sustained while out_tready is high; the path holds one
// insertion cell per stacked input, then the select register and the result
// register. ready is computed per stage, so bubbles close up under a stalled
// output and new words are taken while a result waits. synchronous reset
// clears the valid bits and loads ratio 65536 and active inputs 8.

module stack_percentile_quality import spq_pkg::*; #(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int QUALITY_BITS = QUALITY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // quality_0 .. quality_N-1 from bit 0 up, zero padded to whole bytes
  input  logic [((STACK_DEPTH*QUALITY_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // target_quality, closeness_0 .. closeness_N-1 from bit 0 up, zero padded
  output logic [(((STACK_DEPTH+1)*QUALITY_BITS+7)/8)*8-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int D  = STACK_DEPTH;
  localparam int QB = QUALITY_BITS;
  localparam int CW = $clog2(D+1);
  localparam logic signed [QB-1:0] NEG_ONE = {2'b11, {(QB-2){1'b0}}};
  localparam logic signed [QB-1:0] POS_ONE = {2'b01, {(QB-2){1'b0}}};

  logic [RATIO_W-1:0]  ratio_r;
  logic [ACTIVE_W-1:0] active_r;
  logic [CW-1:0]       used;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= RATIO_RESET;
      active_r <= ACTIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_RATIO:  ratio_r  <= cfg_wdata[RATIO_W-1:0];
        REG_ACTIVE: active_r <= cfg_wdata[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // inputs in use, clamped to the stack depth
  assign used = (active_r > ACTIVE_W'(D)) ? CW'(D) : CW'(active_r);

  // sorting chain
  logic                 ch_valid [D+1];
  logic                 ch_ready [D+1];
  logic signed [QB-1:0] ch_q   [D+1][D];
  logic signed [QB-1:0] ch_srt [D+1][D];
  logic [CW-1:0]        ch_cnt [D+1];

  for (genvar i = 0; i < D; i++) begin : g_head
    assign ch_q[0][i]   = in_tdata[i*QB +: QB];
    assign ch_srt[0][i] = '0;
  end
  assign ch_cnt[0]   = '0;
  assign ch_valid[0] = in_tvalid;
  assign in_tready   = ch_ready[0];

  for (genvar k = 0; k < D; k++) begin : g_cell
    spq_cell #(
      .STACK_DEPTH (D),
      .QUALITY_BITS(QB),
      .IDX         (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .used     (used),
      .in_valid (ch_valid[k]),
      .in_ready (ch_ready[k]),
      .in_q     (ch_q[k]),
      .in_srt   (ch_srt[k]),
      .in_cnt   (ch_cnt[k]),
      .out_valid(ch_valid[k+1]),
      .out_ready(ch_ready[k+1]),
      .out_q    (ch_q[k+1]),
      .out_srt  (ch_srt[k+1]),
      .out_cnt  (ch_cnt[k+1])
    );
  end

  // percentile pick
  logic                 sel_valid;
  logic                 sel_ready;
  logic signed [QB-1:0] sel_q [D];
  logic signed [QB-1:0] sel_target;

  spq_select #(
    .STACK_DEPTH (D),
    .QUALITY_BITS(QB)
  ) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .ratio     (ratio_r),
    .in_valid  (ch_valid[D]),
    .in_ready  (ch_ready[D]),
    .in_q      (ch_q[D]),
    .in_srt    (ch_srt[D]),
    .in_cnt    (ch_cnt[D]),
    .out_valid (sel_valid),
    .out_ready (sel_ready),
    .out_q     (sel_q),
    .out_target(sel_target)
  );

  // scoring and result register
  logic signed [QB-1:0] res_target;
  logic signed [QB-1:0] res_score [D];

  spq_score #(
    .STACK_DEPTH (D),
    .QUALITY_BITS(QB)
  ) u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .used      (used),
    .in_valid  (sel_valid),
    .in_ready  (sel_ready),
    .in_q      (sel_q),
    .in_target (sel_target),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_target(res_target),
    .out_score (res_score)
  );

  // pack the result word
  always_comb begin
    out_tdata = '0;
    out_tdata[QB-1:0] = res_target;
    for (int i = 0; i < D; i++) begin
      out_tdata[(i+1)*QB +: QB] = res_score[i];
    end
  end

  // input is only refused when a result is held by the sink
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // target is either the empty marker or a positive quality
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_target == NEG_ONE || res_target > 0))
    else $error("target out of the valid set");

  for (genvar i = 0; i < D; i++) begin : g_chk
    // no valid input means every lane is marked empty
    assert property (@(posedge clk) disable iff (!rst_n)
      (out_tvalid && res_target == NEG_ONE) |-> (res_score[i] == NEG_ONE))
      else $error("lane scored although no input was valid");

    // a closeness never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> (res_score[i] <= POS_ONE))
      else $error("closeness above one");
  end

endmodule

[hdl/spq_cell.sv]
// spq_cell: one insertion cell of the sorting chain, registers one word
// depends on spq_pkg; chained inside stack_percentile_quality

module spq_cell import spq_pkg::*; #(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int QUALITY_BITS = QUALITY_BITS_DEF,
  parameter int IDX          = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(STACK_DEPTH+1)-1:0] used,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [QUALITY_BITS-1:0] in_q   [STACK_DEPTH],
  input  logic signed [QUALITY_BITS-1:0] in_srt [STACK_DEPTH],
  input  logic [$clog2(STACK_DEPTH+1)-1:0] in_cnt,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [QUALITY_BITS-1:0] out_q   [STACK_DEPTH],
  output logic signed [QUALITY_BITS-1:0] out_srt [STACK_DEPTH],
  output logic [$clog2(STACK_DEPTH+1)-1:0] out_cnt
);

  localparam int CW = $clog2(STACK_DEPTH+1);

  logic                           valid_r;
  logic signed [QUALITY_BITS-1:0] q_r   [STACK_DEPTH];
  logic signed [QUALITY_BITS-1:0] srt_r [STACK_DEPTH];
  logic [CW-1:0]                  cnt_r;

  logic                           take;
  logic [STACK_DEPTH-1:0]         le_mask;
  logic [CW-1:0]                  pos;
  logic signed [QUALITY_BITS-1:0] srt_nxt [STACK_DEPTH];
  logic [CW-1:0]                  cnt_nxt;
  logic signed [QUALITY_BITS-1:0] qv;

  assign qv   = in_q[IDX];
  assign take = (CW'(IDX) < used) && (qv > 0);

  // insertion point: number of held entries not above the new value
  always_comb begin
    for (int j = 0; j < STACK_DEPTH; j++) begin
      le_mask[j] = (CW'(j) < in_cnt) && (in_srt[j] <= qv);
    end
    pos = CW'($countones(le_mask));
  end

  // open a slot at the insertion point and shift the larger entries up
  always_comb begin
    for (int j = 0; j < STACK_DEPTH; j++) begin
      if (!take || CW'(j) < pos) begin
        srt_nxt[j] = in_srt[j];
      end else if (CW'(j) == pos) begin
        srt_nxt[j] = qv;
      end else begin
        srt_nxt[j] = in_srt[(j == 0) ? 0 : j-1];
      end
    end
    cnt_nxt = take ? in_cnt + CW'(1) : in_cnt;
  end

  assign in_ready = !valid_r || out_ready;

  // word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_r   <= in_q;
      srt_r <= srt_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_q     = q_r;
  assign out_srt   = srt_r;
  assign out_cnt   = cnt_r;

endmodule

[hdl/spq_select.sv]
// spq_select: picks the percentile entry out of the sorted stack, registered
// depends on spq_pkg; fed by the last spq_cell

module spq_select import spq_pkg::*; #(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int QUALITY_BITS = QUALITY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [RATIO_W-1:0]             ratio,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [QUALITY_BITS-1:0] in_q   [STACK_DEPTH],
  input  logic signed [QUALITY_BITS-1:0] in_srt [STACK_DEPTH],
  input  logic [$clog2(STACK_DEPTH+1)-1:0] in_cnt,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [QUALITY_BITS-1:0] out_q [STACK_DEPTH],
  output logic signed [QUALITY_BITS-1:0] out_target
);

  localparam int CW = $clog2(STACK_DEPTH+1);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam int PW = CW + RATIO_W;
  localparam logic signed [QUALITY_BITS-1:0] NEG_ONE = {2'b11, {(QUALITY_BITS-2){1'b0}}};

  logic                           valid_r;
  logic signed [QUALITY_BITS-1:0] q_r [STACK_DEPTH];
  logic signed [QUALITY_BITS-1:0] target_r;

  logic [PW-1:0]                  prod;
  logic [CW:0]                    rank;
  logic [CW-1:0]                  cnt_m1;
  logic [CW-1:0]                  rank_c;
  logic signed [QUALITY_BITS-1:0] target_nxt;

  // rank = floor(count * ratio), clamped to count - 1
  always_comb begin
    prod   = PW'(in_cnt) * PW'(ratio);
    rank   = prod[PW-1:RATIO_FRAC];
    cnt_m1 = in_cnt - CW'(1);
    rank_c = (rank > {1'b0, cnt_m1}) ? cnt_m1 : rank[CW-1:0];
    if (in_cnt == '0) begin
      target_nxt = NEG_ONE;
    end else begin
      target_nxt = in_srt[rank_c[IW-1:0]];
    end
  end

  assign in_ready = !valid_r || out_ready;

  // word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_r      <= in_q;
      target_r <= target_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_q      = q_r;
  assign out_target = target_r;

endmodule

[hdl/spq_score.sv]
// spq_score: closeness of each input to the target, saturated, output register
// depends on spq_pkg; fed by spq_select, drives the result channel

module spq_score import spq_pkg::*; #(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int QUALITY_BITS = QUALITY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(STACK_DEPTH+1)-1:0] used,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [QUALITY_BITS-1:0] in_q [STACK_DEPTH],
  input  logic signed [QUALITY_BITS-1:0] in_target,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [QUALITY_BITS-1:0] out_target,
  output logic signed [QUALITY_BITS-1:0] out_score [STACK_DEPTH]
);

  localparam int CW = $clog2(STACK_DEPTH+1);
  localparam int QB = QUALITY_BITS;
  localparam logic signed [QB-1:0] NEG_ONE = {2'b11, {(QB-2){1'b0}}};
  localparam logic signed [QB+1:0] ONE_X   = {4'b0001, {(QB-2){1'b0}}};
  localparam logic signed [QB-1:0] Q_MAX   = {1'b0, {(QB-1){1'b1}}};
  localparam logic signed [QB-1:0] Q_MIN   = {1'b1, {(QB-1){1'b0}}};

  logic                 valid_r;
  logic signed [QB-1:0] target_r;
  logic signed [QB-1:0] score_r [STACK_DEPTH];

  logic signed [QB:0]   diff   [STACK_DEPTH];
  logic signed [QB+1:0] adiff  [STACK_DEPTH];
  logic signed [QB+1:0] raw    [STACK_DEPTH];
  logic signed [QB-1:0] score_nxt [STACK_DEPTH];

  // per lane: 1 - |q - target|, saturated; unused or empty lanes get -1
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      diff[i]  = {in_q[i][QB-1], in_q[i]} - {in_target[QB-1], in_target};
      adiff[i] = diff[i][QB] ? -{diff[i][QB], diff[i]} : {diff[i][QB], diff[i]};
      raw[i]   = ONE_X - adiff[i];
      if (!(CW'(i) < used) || !(in_q[i] > 0)) begin
        score_nxt[i] = NEG_ONE;
      end else if (raw[i][QB+1:QB-1] != 3'b000 && raw[i][QB+1:QB-1] != 3'b111) begin
        score_nxt[i] = raw[i][QB+1] ? Q_MIN : Q_MAX;
      end else begin
        score_nxt[i] = raw[i][QB-1:0];
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  // result word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      target_r <= in_target;
      score_r  <= score_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_target = target_r;
  assign out_score  = score_r;

endmodule
